@@ rtl/cif_pkg.sv @@
// ----------------------------------------------------------------------------
// CpG island content filter package
// Shared widths, character codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cif_pkg;

    localparam int COUNT_BITS_DEF = 20;  // default counter width
    localparam int FIELD_W        = 20;  // width of the count fields of a result
    localparam int GC_W           = 17;  // min_gc, unsigned Q1.16
    localparam int OE_W           = 19;  // min_oe, unsigned Q3.16
    localparam int FRAC_BITS      = 16;  // fraction bits of both thresholds
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 19;

    localparam logic [GC_W-1:0] MIN_GC_RESET = 17'd32768;
    localparam logic [OE_W-1:0] MIN_OE_RESET = 19'd39322;

    localparam logic [7:0] CHAR_C_UPPER = 8'h43;
    localparam logic [7:0] CHAR_C_LOWER = 8'h63;
    localparam logic [7:0] CHAR_G_UPPER = 8'h47;
    localparam logic [7:0] CHAR_G_LOWER = 8'h67;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_GC = 1'b0,
        CFG_MIN_OE = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_COUNT,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_CMP
    } state_t;

    typedef struct packed {
        logic count_en;  // take one base into the counters
        logic mul1_en;   // first products from the counters
        logic mul2_en;   // split product of the ratio right side, GC compare
        logic sum_en;    // join the split product
        logic finish;    // load the result, clear the counters
    } cif_cmd_t;

    typedef struct packed {
        logic out_free;  // result register can take a new verdict
    } cif_stat_t;

endpackage

@@ rtl/cif_ctrl.sv @@
// ----------------------------------------------------------------------------
// CpG island content filter controller
// Sequences counting and the multi-cycle verdict evaluation.
// ----------------------------------------------------------------------------
module cif_ctrl
    import cif_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      last,
    output logic      in_ready,
    input  cif_stat_t stat,
    output cif_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_COUNT:
            begin
                if (in_valid && last)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_SUM;
            S_SUM:   state_next = S_CMP;
            S_CMP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_COUNT;
                end
            end
            default: state_next = S_COUNT;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_COUNT:
            begin
                in_ready     = 1'b1;
                cmd.count_en = in_valid;
            end
            S_MUL1:  cmd.mul1_en = 1'b1;
            S_MUL2:  cmd.mul2_en = 1'b1;
            S_SUM:   cmd.sum_en  = 1'b1;
            S_CMP:   cmd.finish  = stat.out_free;
            default: in_ready    = 1'b0;
        endcase
    end

endmodule

@@ rtl/cif_datapath.sv @@
// ----------------------------------------------------------------------------
// CpG island content filter datapath
// Saturating base counters, threshold registers, staged cross-multiplication
// and the result register.
// ----------------------------------------------------------------------------
module cif_datapath
    import cif_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cif_cmd_t              cmd,
    output cif_stat_t             stat,
    input  logic [7:0]            base,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  keep,
    output logic [FIELD_W-1:0]    region_length,
    output logic [FIELD_W-1:0]    c_count,
    output logic [FIELD_W-1:0]    g_count,
    output logic [FIELD_W-1:0]    cg_count,
    output logic                  overflow
);

    localparam int CB     = COUNT_BITS;
    localparam int PGC_W  = GC_W + CB;
    localparam int PCL_W  = 2 * CB;
    localparam int POC_W  = OE_W + CB;
    localparam int HI_W   = OE_W + CB;
    localparam int RHS_W  = OE_W + 2 * CB;
    localparam int LHS_W  = PCL_W + FRAC_BITS;
    localparam int CMP_W  = (RHS_W > LHS_W) ? RHS_W : LHS_W;
    localparam logic [CB-1:0] CNT_MAX = '1;

    // thresholds
    logic [GC_W-1:0] min_gc_reg;
    logic [OE_W-1:0] min_oe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gc_reg <= MIN_GC_RESET;
            min_oe_reg <= MIN_OE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_GC: min_gc_reg <= cfg_data[GC_W-1:0];
                CFG_MIN_OE: min_oe_reg <= cfg_data[OE_W-1:0];
                default:    min_gc_reg <= min_gc_reg;
            endcase
        end
    end

    // counters
    logic [CB-1:0] len_reg, len_next;
    logic [CB-1:0] c_reg, c_next;
    logic [CB-1:0] g_reg, g_next;
    logic [CB-1:0] cg_reg, cg_next;
    logic          prev_c_reg, prev_c_next;
    logic          sat_reg, sat_next;
    logic          is_c, is_g;
    logic          len_max, c_max, g_max, cg_max;

    assign is_c    = (base == CHAR_C_UPPER) || (base == CHAR_C_LOWER);
    assign is_g    = (base == CHAR_G_UPPER) || (base == CHAR_G_LOWER);
    assign len_max = (len_reg == CNT_MAX);
    assign c_max   = (c_reg == CNT_MAX);
    assign g_max   = (g_reg == CNT_MAX);
    assign cg_max  = (cg_reg == CNT_MAX);

    always_comb
    begin
        len_next    = len_reg;
        c_next      = c_reg;
        g_next      = g_reg;
        cg_next     = cg_reg;
        prev_c_next = prev_c_reg;
        sat_next    = sat_reg;
        if (cmd.count_en)
        begin
            // hold a full counter and flag it
            if (!len_max)
            begin
                len_next = CB'(len_reg + 1'b1);
            end
            if (is_c && !c_max)
            begin
                c_next = CB'(c_reg + 1'b1);
            end
            if (is_g && !g_max)
            begin
                g_next = CB'(g_reg + 1'b1);
            end
            if (is_g && prev_c_reg && !cg_max)
            begin
                cg_next = CB'(cg_reg + 1'b1);
            end
            sat_next = sat_reg | len_max | (is_c & c_max) | (is_g & g_max)
                     | (is_g & prev_c_reg & cg_max);
            prev_c_next = is_c;
        end
        else if (cmd.finish)
        begin
            len_next    = '0;
            c_next      = '0;
            g_next      = '0;
            cg_next     = '0;
            prev_c_next = 1'b0;
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            c_reg      <= '0;
            g_reg      <= '0;
            cg_reg     <= '0;
            prev_c_reg <= 1'b0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            c_reg      <= c_next;
            g_reg      <= g_next;
            cg_reg     <= cg_next;
            prev_c_reg <= prev_c_next;
            sat_reg    <= sat_next;
        end
    end

    // verdict pipeline
    logic [PGC_W-1:0] pgc_reg;    // min_gc * len
    logic [PCL_W-1:0] pcl_reg;    // cg * len
    logic [POC_W-1:0] poc_reg;    // min_oe * c
    logic [CB:0]      gcsum_reg;  // c + g
    logic             zero_reg;   // c or g absent
    logic [PCL_W-1:0] lo_reg;
    logic [HI_W-1:0]  hi_reg;
    logic             gc_ok_reg;
    logic [RHS_W-1:0] rhs_reg;
    logic [CMP_W-1:0] lhs_cmp, rhs_cmp;
    logic             oe_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1_en)
        begin
            pgc_reg   <= PGC_W'(min_gc_reg) * PGC_W'(len_reg);
            pcl_reg   <= PCL_W'(cg_reg) * PCL_W'(len_reg);
            poc_reg   <= POC_W'(min_oe_reg) * POC_W'(c_reg);
            gcsum_reg <= (CB+1)'(c_reg) + (CB+1)'(g_reg);
            zero_reg  <= (c_reg == '0) || (g_reg == '0);
        end
        if (cmd.mul2_en)
        begin
            lo_reg    <= PCL_W'(poc_reg[CB-1:0]) * PCL_W'(g_reg);
            hi_reg    <= HI_W'(poc_reg[POC_W-1:CB]) * HI_W'(g_reg);
            gc_ok_reg <= ({gcsum_reg, {FRAC_BITS{1'b0}}} >= pgc_reg);
        end
        if (cmd.sum_en)
        begin
            rhs_reg <= (RHS_W'(hi_reg) << CB) + RHS_W'(lo_reg);
        end
    end

    assign lhs_cmp = CMP_W'({pcl_reg, {FRAC_BITS{1'b0}}});
    assign rhs_cmp = CMP_W'(rhs_reg);
    assign oe_ok   = zero_reg ? (min_oe_reg == '0) : (lhs_cmp >= rhs_cmp);

    // result register
    logic               out_valid_reg;
    logic               keep_reg;
    logic [FIELD_W-1:0] len_out_reg, c_out_reg, g_out_reg, cg_out_reg;
    logic               ovf_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            keep_reg    <= gc_ok_reg & oe_ok;
            len_out_reg <= FIELD_W'(len_reg);
            c_out_reg   <= FIELD_W'(c_reg);
            g_out_reg   <= FIELD_W'(g_reg);
            cg_out_reg  <= FIELD_W'(cg_reg);
            ovf_out_reg <= sat_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign keep          = keep_reg;
    assign region_length = len_out_reg;
    assign c_count       = c_out_reg;
    assign g_count       = g_out_reg;
    assign cg_count      = cg_out_reg;
    assign overflow      = ovf_out_reg;

endmodule

@@ rtl/cpg_island_content_filter_unit.sv @@
// ----------------------------------------------------------------------------
// CpG island content filter unit
// Counts bases, C, G and CpG pairs over one region and judges it against
// GC fraction and observed/expected CpG thresholds.
// ----------------------------------------------------------------------------
// Stream the bases of one region as items on the input channel, one ASCII
// character each, with last set on the final base; letter case is ignored.
// Every base that is not the final one is taken as soon as it is offered, so a
// region streams at one base per clock. The final base starts the verdict:
// the controller then steps the datapath through two multiply stages, one
// wide add and one wide compare, and the result item is loaded in the
// compare step, which waits while the previous result has not yet
// been taken; the next region's first base is accepted in the cycle
// after that load. A region is kept when (c + g) * 2^16 >= min_gc * length
// and cg * length * 2^16 >= min_oe * c * g; if C or G is absent the ratio
// test passes only with min_oe at zero. Counters hold at 2^COUNT_BITS - 1
// and raise overflow; the count fields show their low 20 bits. Write the
// thresholds only while no region is in progress.
// ----------------------------------------------------------------------------
module cpg_island_content_filter_unit
    import cif_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // base items
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            base,
    input  logic                  last,
    // threshold writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // verdict items
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  keep,
    output logic [FIELD_W-1:0]    region_length,
    output logic [FIELD_W-1:0]    c_count,
    output logic [FIELD_W-1:0]    g_count,
    output logic [FIELD_W-1:0]    cg_count,
    output logic                  overflow
);

    cif_cmd_t  cmd;
    cif_stat_t stat;

    // sequence counting and the verdict steps
    cif_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // counters, products and the result register
    cif_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .base          (base),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .keep          (keep),
        .region_length (region_length),
        .c_count       (c_count),
        .g_count       (g_count),
        .cg_count      (cg_count),
        .overflow      (overflow)
    );

endmodule

@@ rtl/cif_checker.sv @@
// ----------------------------------------------------------------------------
// CpG island content filter checker
// Port-level assertions on the filter unit, attached by bind.
// ----------------------------------------------------------------------------
module cif_checker
    import cif_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  last,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  keep,
    input logic [FIELD_W-1:0]    region_length,
    input logic [FIELD_W-1:0]    c_count,
    input logic [FIELD_W-1:0]    g_count,
    input logic [FIELD_W-1:0]    cg_count,
    input logic                  overflow
);

    // a stalled result stays valid and holds its verdict, length, pair count and overflow flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(keep)
            && $stable(region_length) && $stable(cg_count) && $stable(overflow))
    else $error("stalled result changed");

    // every region has at least one base
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> region_length != '0)
    else $error("empty region reported");

    // without saturation, pairs never outnumber C or G and C plus G fits the length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |-> cg_count <= c_count && cg_count <= g_count
            && ({1'b0, c_count} + {1'b0, g_count}) <= {1'b0, region_length})
    else $error("inconsistent counts");

    // the final base starts the verdict, so no base is taken right after it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
    else $error("base taken during verdict");

endmodule

bind cpg_island_content_filter_unit cif_checker u_cif_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .keep          (keep),
    .region_length (region_length),
    .c_count       (c_count),
    .g_count       (g_count),
    .cg_count      (cg_count),
    .overflow      (overflow)
);
